### design/ip6_multicast_prefix_table_macros.svh
// ----------------------------------------------------------------------------
// ip6_multicast_prefix_table_macros
// Assertion macros used by the multicast prefix table sequencer.
// ----------------------------------------------------------------------------
`ifndef IP6_MULTICAST_PREFIX_TABLE_MACROS_SVH
`define IP6_MULTICAST_PREFIX_TABLE_MACROS_SVH

`ifndef ASSERT_OFF
// Condition implies consequence in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rstn, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (c)) else $error(msg);
// Condition implies consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (c)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rstn, a, c, msg)
`define ASSERT_NEXT(lbl, clk, rstn, a, c, msg)
`endif

`endif

### design/ip6mpt_pkg.sv
// ----------------------------------------------------------------------------
// ip6mpt_pkg
// Types, codes and helpers of the IPv6 multicast prefix table.
// ----------------------------------------------------------------------------
package ip6mpt_pkg;

    localparam int DEF_SLOTS  = 1024;
    localparam int DEF_TABLES = 256;
    localparam int LEN_W      = 9;
    localparam int TBL_W      = 8;
    localparam int VALUE_W    = 32;
    localparam int ADDR128_W  = 128;

    localparam logic [LEN_W-1:0] FULL_LEN   = 9'd256;
    localparam logic [LEN_W-1:0] GROUP_BITS = 9'd128;

    typedef enum logic [2:0] {
        OP_INSERT  = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_EXACT   = 3'd2,
        OP_LONGEST = 3'd3,
        OP_COVER   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CTL_CLEAR,
        CTL_IDLE,
        CTL_SCAN,
        CTL_DRAIN,
        CTL_FINISH
    } state_t;

    typedef struct packed {
        logic                 valid;
        logic [TBL_W-1:0]     tbl;
        logic [LEN_W-1:0]     len;
        logic [ADDR128_W-1:0] grp;
        logic [ADDR128_W-1:0] src;
        logic [VALUE_W-1:0]   value;
    } entry_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic clear;
        logic commit;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic out_busy;
    } dp_status_t;

    // Mask of the top min(len,128) bits of a group address.
    function automatic logic [ADDR128_W-1:0] mask_top(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] g;
        g = (len > GROUP_BITS) ? GROUP_BITS : len;
        return ~({ADDR128_W{1'b1}} >> g);
    endfunction

endpackage

### design/ip6mpt_ctrl.sv
// ----------------------------------------------------------------------------
// ip6mpt_ctrl
// Sequencer: clearing pass, slot scan, drain, commit and result hand-off.
// ----------------------------------------------------------------------------
`include "ip6_multicast_prefix_table_macros.svh"

module ip6mpt_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  ip6mpt_pkg::dp_status_t status_i,
    output ip6mpt_pkg::ctrl_cmd_t  cmd_o
);
    import ip6mpt_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTL_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CTL_CLEAR: begin
                if (status_i.cnt_last) state_next = CTL_IDLE;
            end
            CTL_IDLE: begin
                if (s_valid) state_next = CTL_SCAN;
            end
            CTL_SCAN: begin
                if (status_i.cnt_last) state_next = CTL_DRAIN;
            end
            CTL_DRAIN: begin
                state_next = CTL_FINISH;
            end
            CTL_FINISH: begin
                if (!status_i.out_busy) state_next = CTL_IDLE;
            end
            default: begin
                state_next = CTL_CLEAR;
            end
        endcase
    end

    always_comb begin
        cmd_o   = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            CTL_CLEAR: begin
                cmd_o.clear = 1'b1;
            end
            CTL_IDLE: begin
                s_ready    = 1'b1;
                cmd_o.load = s_valid;
            end
            CTL_SCAN: begin
                cmd_o.scan = 1'b1;
            end
            CTL_DRAIN: begin
            end
            CTL_FINISH: begin
                cmd_o.commit   = !status_i.out_busy;
                cmd_o.out_load = !status_i.out_busy;
            end
            default: begin
            end
        endcase
    end

    `ASSERT_IMPLY(a_commit_free, aclk, aresetn, cmd_o.commit, !status_i.out_busy, "commit while output busy")
    `ASSERT_NEXT(a_load_scan, aclk, aresetn, cmd_o.load, state_reg == CTL_SCAN, "load not followed by scan")
    `ASSERT_NEXT(a_scan_end, aclk, aresetn, cmd_o.scan && status_i.cnt_last, state_reg == CTL_DRAIN, "scan end missed")

endmodule

### design/ip6mpt_dp.sv
// ----------------------------------------------------------------------------
// ip6mpt_dp
// Datapath: slot memory, scan counter, key compare, match tracking, output.
// ----------------------------------------------------------------------------
module ip6mpt_dp #(
    parameter int SLOTS  = ip6mpt_pkg::DEF_SLOTS,
    parameter int TABLES = ip6mpt_pkg::DEF_TABLES
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ip6mpt_pkg::ctrl_cmd_t  cmd_i,
    output ip6mpt_pkg::dp_status_t status_o,
    input  logic [2:0]             s_op,
    input  logic [7:0]             s_table_index,
    input  logic [63:0]            s_group_high,
    input  logic [63:0]            s_group_low,
    input  logic [63:0]            s_source_high,
    input  logic [63:0]            s_source_low,
    input  logic [8:0]             s_prefix_len,
    input  logic [31:0]            s_value_in,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_found,
    output logic [31:0]            m_value_out,
    output logic [8:0]             m_matched_len,
    output logic [1:0]             m_status
);
    import ip6mpt_pkg::*;

    localparam int ADDR_W = $clog2(SLOTS);
    localparam int TBL_N  = 2 ** TBL_W;

    // Table index reduced modulo TABLES, one entry per possible index.
    function automatic logic [TBL_N*TBL_W-1:0] tbl_mod_lut();
        logic [TBL_N*TBL_W-1:0] lut;
        lut = '0;
        for (int i = 0; i < TBL_N; i++) begin
            lut[i*TBL_W +: TBL_W] = TBL_W'(i % TABLES);
        end
        return lut;
    endfunction

    localparam logic [TBL_N*TBL_W-1:0] TBL_LUT = tbl_mod_lut();

    entry_t mem [SLOTS];

    logic [ADDR_W-1:0]    cnt_reg;
    op_t                  op_reg;
    logic [TBL_W-1:0]     tbl_reg;
    logic [ADDR128_W-1:0] gin_reg, sin_reg;
    logic [LEN_W-1:0]     len_reg, maxlen_reg;
    logic [VALUE_W-1:0]   val_reg;
    entry_t               rd_reg;
    logic                 rd_vld_reg;
    logic [ADDR_W-1:0]    rd_addr_reg;
    logic                 hit_vld_reg, free_vld_reg, best_vld_reg;
    logic [ADDR_W-1:0]    hit_addr_reg, free_addr_reg;
    logic [VALUE_W-1:0]   hit_val_reg, best_val_reg;
    logic [LEN_W-1:0]     best_len_reg;
    logic                 m_valid_reg, m_found_reg;
    logic [VALUE_W-1:0]   m_value_reg;
    logic [LEN_W-1:0]     m_len_reg;
    status_t              m_status_reg;

    logic [LEN_W-1:0]     len_sat;
    logic [ADDR128_W-1:0] key_grp, key_src, lpm_grp, lpm_src;
    logic                 key_eq, lpm_hit;
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    entry_t               wdata;

    assign len_sat = (s_prefix_len > FULL_LEN) ? FULL_LEN : s_prefix_len;

    // Key of the request at its own length, and at the length of the slot read.
    assign key_grp = gin_reg & mask_top(len_reg);
    assign key_src = (len_reg == FULL_LEN) ? sin_reg : '0;
    assign lpm_grp = gin_reg & mask_top(rd_reg.len);
    assign lpm_src = (rd_reg.len == FULL_LEN) ? sin_reg : '0;

    assign key_eq = rd_reg.valid && rd_reg.tbl == tbl_reg && rd_reg.len == len_reg &&
                    rd_reg.grp == key_grp && rd_reg.src == key_src;
    assign lpm_hit = rd_reg.valid && rd_reg.tbl == tbl_reg && rd_reg.len <= maxlen_reg &&
                     (!best_vld_reg || rd_reg.len > best_len_reg) &&
                     rd_reg.grp == lpm_grp && rd_reg.src == lpm_src;

    always_comb begin
        we    = 1'b0;
        waddr = cnt_reg;
        wdata = '0;
        if (cmd_i.clear) begin
            we = 1'b1;
        end else if (cmd_i.commit) begin
            if (op_reg == OP_INSERT) begin
                we          = hit_vld_reg || free_vld_reg;
                waddr       = hit_vld_reg ? hit_addr_reg : free_addr_reg;
                wdata.valid = 1'b1;
                wdata.tbl   = tbl_reg;
                wdata.len   = len_reg;
                wdata.grp   = key_grp;
                wdata.src   = key_src;
                wdata.value = val_reg;
            end else if (op_reg == OP_REMOVE) begin
                we    = hit_vld_reg;
                waddr = hit_addr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (cmd_i.scan) begin
            rd_reg <= mem[cnt_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd_i.scan;
            if (cmd_i.load) begin
                cnt_reg <= '0;
            end else if (cmd_i.scan || cmd_i.clear) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg <= cnt_reg;
        if (cmd_i.load) begin
            op_reg   <= op_t'(s_op);
            tbl_reg  <= TBL_LUT[{s_table_index, 3'b000} +: TBL_W];
            gin_reg  <= {s_group_high, s_group_low};
            sin_reg  <= {s_source_high, s_source_low};
            len_reg  <= len_sat;
            val_reg  <= s_value_in;
            if (s_op == OP_COVER) begin
                if (len_sat == FULL_LEN) begin
                    maxlen_reg <= GROUP_BITS;
                end else if (len_sat == '0) begin
                    maxlen_reg <= '0;
                end else begin
                    maxlen_reg <= len_sat - 1'b1;
                end
            end else begin
                maxlen_reg <= len_sat;
            end
            hit_vld_reg  <= 1'b0;
            free_vld_reg <= 1'b0;
            best_vld_reg <= 1'b0;
        end else if (rd_vld_reg) begin
            if (key_eq && !hit_vld_reg) begin
                hit_vld_reg  <= 1'b1;
                hit_addr_reg <= rd_addr_reg;
                hit_val_reg  <= rd_reg.value;
            end
            if (!rd_reg.valid && !free_vld_reg) begin
                free_vld_reg  <= 1'b1;
                free_addr_reg <= rd_addr_reg;
            end
            if (lpm_hit) begin
                best_vld_reg <= 1'b1;
                best_len_reg <= rd_reg.len;
                best_val_reg <= rd_reg.value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd_i.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.out_load) begin
            m_found_reg  <= 1'b0;
            m_value_reg  <= '0;
            m_len_reg    <= '0;
            m_status_reg <= STAT_DONE;
            unique case (op_reg)
                OP_INSERT: begin
                    if (!hit_vld_reg && !free_vld_reg) m_status_reg <= STAT_FULL;
                end
                OP_REMOVE: begin
                    if (!hit_vld_reg) m_status_reg <= STAT_NOT_FOUND;
                end
                OP_EXACT: begin
                    m_found_reg <= hit_vld_reg;
                    m_value_reg <= hit_vld_reg ? hit_val_reg : '0;
                    m_len_reg   <= hit_vld_reg ? len_reg : '0;
                end
                OP_LONGEST, OP_COVER: begin
                    m_found_reg <= best_vld_reg;
                    m_value_reg <= best_vld_reg ? best_val_reg : '0;
                    m_len_reg   <= best_vld_reg ? best_len_reg : '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign status_o.cnt_last = (cnt_reg == ADDR_W'(SLOTS - 1));
    assign status_o.out_busy = m_valid_reg && !m_ready;

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_value_out   = m_value_reg;
    assign m_matched_len = m_len_reg;
    assign m_status      = m_status_reg;

endmodule

### design/ip6_multicast_prefix_table.sv
// A new item is accepted only after the previous result has been loaded into the
// output register. Every operation reads all SLOTS entries of the slot memory, one per
// cycle, then commits a write for insert and remove and loads the output register.
// After reset a clearing pass invalidates every slot; no item is accepted until it
// ends. A finished result waits in the output register.
// ----------------------------------------------------------------------------
// ip6_multicast_prefix_table
// IPv6 multicast route table with exact, longest-prefix and cover lookups.
// ----------------------------------------------------------------------------
module ip6_multicast_prefix_table #(
    parameter int SLOTS  = ip6mpt_pkg::DEF_SLOTS,
    parameter int TABLES = ip6mpt_pkg::DEF_TABLES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [7:0]  s_table_index,
    input  logic [63:0] s_group_high,
    input  logic [63:0] s_group_low,
    input  logic [63:0] s_source_high,
    input  logic [63:0] s_source_low,
    input  logic [8:0]  s_prefix_len,
    input  logic [31:0] s_value_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [31:0] m_value_out,
    output logic [8:0]  m_matched_len,
    output logic [1:0]  m_status
);
    import ip6mpt_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    ip6mpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .status_i (dp_status),
        .cmd_o    (cmd)
    );

    ip6mpt_dp #(
        .SLOTS  (SLOTS),
        .TABLES (TABLES)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_i         (cmd),
        .status_o      (dp_status),
        .s_op          (s_op),
        .s_table_index (s_table_index),
        .s_group_high  (s_group_high),
        .s_group_low   (s_group_low),
        .s_source_high (s_source_high),
        .s_source_low  (s_source_low),
        .s_prefix_len  (s_prefix_len),
        .s_value_in    (s_value_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_value_out   (m_value_out),
        .m_matched_len (m_matched_len),
        .m_status      (m_status)
    );

endmodule
